// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Checked during reset as well: reset implies consequent in the following cycle.
`define ASSERT_AFTER_RESET(lbl, clk, rst_n, cons, msg) \
    lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bda_pkg.sv =====
// ---------------------------------------------------------------------------
// Button debounce package
// Widths, types, register indexes, mode codes, reset values and a saturating increment.
// ---------------------------------------------------------------------------
package bda_pkg;

    localparam int CountWidth = 16;
    localparam int CfgWidth   = 16;
    localparam int CmpWidth   = (CountWidth > CfgWidth) ? CountWidth : CfgWidth;
    localparam int IdxWidth   = 3;

    typedef logic [CountWidth-1:0] t_count;
    typedef logic [CfgWidth-1:0]   t_cfg;
    typedef logic [CmpWidth-1:0]   t_cmp;
    typedef logic [IdxWidth-1:0]   t_idx;

    typedef enum logic [1:0] {
        MODE_SINGLE    = 2'd0,
        MODE_REPEAT    = 2'd1,
        MODE_SPEED_ONE = 2'd2,
        MODE_SPEED_TWO = 2'd3
    } t_mode;

    typedef enum logic [IdxWidth-1:0] {
        REG_MODE              = 3'd0,
        REG_DEBOUNCE_TICKS    = 3'd1,
        REG_REPEAT_TICKS      = 3'd2,
        REG_SPEED_ONE_AFTER   = 3'd3,
        REG_SPEED_ONE_TICKS   = 3'd4,
        REG_SPEED_TWO_AFTER   = 3'd5,
        REG_SPEED_TWO_TICKS   = 3'd6
    } t_reg_idx;

    localparam t_cfg RstDebounceTicks  = t_cfg'(20);
    localparam t_cfg RstRepeatTicks    = t_cfg'(500);
    localparam t_cfg RstSpeedOneAfter  = t_cfg'(5);
    localparam t_cfg RstSpeedOneTicks  = t_cfg'(200);
    localparam t_cfg RstSpeedTwoAfter  = t_cfg'(15);
    localparam t_cfg RstSpeedTwoTicks  = t_cfg'(50);

    localparam t_count CountMax = '1;

    function automatic t_count sat_inc(input t_count value);
        return (value == CountMax) ? value : value + t_count'(1);
    endfunction

endpackage

// ===== hdl/bda_if.sv =====
// ---------------------------------------------------------------------------
// Button debounce channels
// Item, result and register write channels with valid/ready handshakes.
// ---------------------------------------------------------------------------
interface bda_item_if;
    logic valid;
    logic ready;
    logic func;
    logic pin_level;

    modport source (output valid, output func, output pin_level, input ready);
    modport sink   (input valid, input func, input pin_level, output ready);
endinterface

interface bda_result_if;
    logic valid;
    logic ready;
    logic pressed;

    modport source (output valid, output pressed, input ready);
    modport sink   (input valid, input pressed, output ready);
endinterface

interface bda_cfg_if;
    logic            valid;
    logic            ready;
    bda_pkg::t_idx   reg_index;
    bda_pkg::t_cfg   reg_data;

    modport source (output valid, output reg_index, output reg_data, input ready);
    modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

// ===== hdl/button_debounce_autorepeat.sv =====
// ---------------------------------------------------------------------------
// Button debounce with accelerated auto-repeat
// Debounces a sampled button pin and raises a pressed flag once or repeatedly.
// ---------------------------------------------------------------------------
// Items arrive on i_item: func 0 is a tick carrying one pin sample, func 1
// reads and clears the pressed flag. Every item yields one transfer on
// o_result carrying the flag (after the tick, or before the clear on a read).
// Registers are written on i_cfg, which is always ready; writes are expected
// only while no item is in flight.
// An accepted item is held in an input register, processed by the counter
// update logic and placed in the result register, from which the result is
// offered. While the receiver takes results, one item is accepted every
// cycle; the single counter update stage sets that rate.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; after that i_item.ready falls until the result
// is taken.
// Synchronous reset clears the counters, the flag and both pipeline stages,
// and loads the register reset values.
// ---------------------------------------------------------------------------
module button_debounce_autorepeat (
    input  logic                i_clk,
    input  logic                i_rst_n,
    bda_item_if.sink            i_item,
    bda_result_if.source        o_result,
    bda_cfg_if.sink             i_cfg
);

    bda_pkg::t_mode  r_mode;
    bda_pkg::t_cfg   r_debounce_ticks;
    bda_pkg::t_cfg   r_repeat_ticks;
    bda_pkg::t_cfg   r_speed_one_after;
    bda_pkg::t_cfg   r_speed_one_ticks;
    bda_pkg::t_cfg   r_speed_two_after;
    bda_pkg::t_cfg   r_speed_two_ticks;

    bda_pkg::t_count r_debounce_count;
    bda_pkg::t_count r_hold_ticks;
    bda_pkg::t_count r_repeat_count;
    logic            r_flag;

    logic            r_in_valid;
    logic            r_func;
    logic            r_pin;
    logic            r_out_valid;
    logic            r_pressed;

    bda_pkg::t_count n_debounce_count;
    bda_pkg::t_count n_hold_ticks;
    bda_pkg::t_count n_repeat_count;
    logic            n_flag;
    logic            n_pressed;

    logic            advance;
    logic            accept;
    logic            counting;
    logic            debounce_idle;
    logic            debounce_busy;
    logic            hold_eq_repeat;
    logic            hold_eq_one;
    logic            hold_eq_two;
    logic            above_one;
    logic            above_two;
    logic            period_done;
    bda_pkg::t_count hold_base;

    assign advance          = !r_out_valid || o_result.ready;
    assign i_item.ready     = !r_in_valid || advance;
    assign accept           = i_item.valid && i_item.ready;
    assign i_cfg.ready      = 1'b1;
    assign o_result.valid   = r_out_valid;
    assign o_result.pressed = r_pressed;

    assign counting      = (r_mode == bda_pkg::MODE_SPEED_ONE)
                        || (r_mode == bda_pkg::MODE_SPEED_TWO);
    assign debounce_idle = (r_debounce_count == '0);
    assign debounce_busy = !debounce_idle && (bda_pkg::t_cmp'(r_debounce_count)
                        < bda_pkg::t_cmp'(r_debounce_ticks));

    assign hold_eq_repeat = bda_pkg::t_cmp'(r_hold_ticks) == bda_pkg::t_cmp'(r_repeat_ticks);
    assign hold_eq_one    = bda_pkg::t_cmp'(r_hold_ticks)
                         == bda_pkg::t_cmp'(r_speed_one_ticks);
    assign hold_eq_two    = bda_pkg::t_cmp'(r_hold_ticks)
                         == bda_pkg::t_cmp'(r_speed_two_ticks);
    assign above_one      = bda_pkg::t_cmp'(r_repeat_count)
                          > bda_pkg::t_cmp'(r_speed_one_after);
    assign above_two      = bda_pkg::t_cmp'(r_repeat_count)
                          > bda_pkg::t_cmp'(r_speed_two_after);

    always_comb begin
        case (r_mode)
            bda_pkg::MODE_REPEAT: begin
                period_done = hold_eq_repeat;
            end
            bda_pkg::MODE_SPEED_ONE: begin
                period_done = (!above_one && hold_eq_repeat) || (above_one && hold_eq_one);
            end
            bda_pkg::MODE_SPEED_TWO: begin
                period_done = (!above_one && hold_eq_repeat) || (above_one && hold_eq_one)
                           || (above_two && hold_eq_two);
            end
            default: begin
                period_done = 1'b0;
            end
        endcase
    end

    assign hold_base = period_done ? '0 : r_hold_ticks;

    always_comb begin
        n_debounce_count = r_debounce_count;
        n_hold_ticks     = r_hold_ticks;
        n_repeat_count   = r_repeat_count;
        n_flag           = r_flag;
        if (r_func) begin
            n_flag = 1'b0;
        end else if ((debounce_idle && r_pin) || debounce_busy) begin
            n_debounce_count = bda_pkg::sat_inc(r_debounce_count);
        end else if (r_pin) begin
            if (hold_base == '0) begin
                n_flag = 1'b1;
                if (counting) begin
                    n_repeat_count = bda_pkg::sat_inc(r_repeat_count);
                end
            end
            n_hold_ticks = bda_pkg::sat_inc(hold_base);
        end else begin
            n_debounce_count = '0;
            n_hold_ticks     = '0;
            n_repeat_count   = '0;
        end
        n_pressed = r_func ? r_flag : n_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode            <= bda_pkg::MODE_SINGLE;
            r_debounce_ticks  <= bda_pkg::RstDebounceTicks;
            r_repeat_ticks    <= bda_pkg::RstRepeatTicks;
            r_speed_one_after <= bda_pkg::RstSpeedOneAfter;
            r_speed_one_ticks <= bda_pkg::RstSpeedOneTicks;
            r_speed_two_after <= bda_pkg::RstSpeedTwoAfter;
            r_speed_two_ticks <= bda_pkg::RstSpeedTwoTicks;
            r_debounce_count  <= '0;
            r_hold_ticks      <= '0;
            r_repeat_count    <= '0;
            r_flag            <= 1'b0;
            r_in_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (bda_pkg::t_reg_idx'(i_cfg.reg_index))
                    bda_pkg::REG_MODE:            r_mode <= bda_pkg::t_mode'(i_cfg.reg_data[1:0]);
                    bda_pkg::REG_DEBOUNCE_TICKS:  r_debounce_ticks  <= i_cfg.reg_data;
                    bda_pkg::REG_REPEAT_TICKS:    r_repeat_ticks    <= i_cfg.reg_data;
                    bda_pkg::REG_SPEED_ONE_AFTER: r_speed_one_after <= i_cfg.reg_data;
                    bda_pkg::REG_SPEED_ONE_TICKS: r_speed_one_ticks <= i_cfg.reg_data;
                    bda_pkg::REG_SPEED_TWO_AFTER: r_speed_two_after <= i_cfg.reg_data;
                    bda_pkg::REG_SPEED_TWO_TICKS: r_speed_two_ticks <= i_cfg.reg_data;
                    default: begin
                    end
                endcase
            end
            if (r_in_valid && advance) begin
                r_debounce_count <= n_debounce_count;
                r_hold_ticks     <= n_hold_ticks;
                r_repeat_count   <= n_repeat_count;
                r_flag           <= n_flag;
            end
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_item.func;
            r_pin  <= i_item.pin_level;
        end
        if (r_in_valid && advance) begin
            r_pressed <= n_pressed;
        end
    end

endmodule

// ===== hdl/bda_checker.sv =====
// ---------------------------------------------------------------------------
// Button debounce port checker
// Watches the top-level channels over time and is bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bda_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_pressed,
    input logic i_cfg_valid,
    input logic i_cfg_ready
);

    `ASSERT_AFTER_RESET(a_reset_empty, i_clk, i_rst_n, !i_out_valid, "result offered after reset")
    `ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_pressed), "stalled result changed")
    `ASSERT_SAME(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready, "item refused while result register empty")
    `ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, (i_in_valid && i_in_ready) ##1 i_out_ready, i_out_valid, "accepted item gave no result")
    `ASSERT_SAME(a_cfg_ready, i_clk, i_rst_n, i_cfg_valid, i_cfg_ready, "register write stalled")

endmodule

bind button_debounce_autorepeat bda_checker u_bda_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_item.valid),
    .i_in_ready   (i_item.ready),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_out_pressed(o_result.pressed),
    .i_cfg_valid  (i_cfg.valid),
    .i_cfg_ready  (i_cfg.ready)
);
